// ===== design/xorshift128plus_random_source_core_assert.svh =====
// Assertion macros for the xorshift128+ random source RTL, used by xrs_back.
`ifndef XORSHIFT128PLUS_RANDOM_SOURCE_CORE_ASSERT_SVH
`define XORSHIFT128PLUS_RANDOM_SOURCE_CORE_ASSERT_SVH
// Property that must hold at every edge outside reset.
`define XRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property whose consequent must hold in the cycle after its antecedent.
`define XRS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

// ===== design/xrs_pkg.sv =====
// Types and constants of the xorshift128+ random source.
`default_nettype none
package xrs_pkg;
  localparam logic [63:0] GAMMA_K  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_A_K  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_B_K  = 64'h94D049BB133111EB;
  // SplitMix64 outputs for seed zero (reset state).
  localparam logic [63:0] SEED0_W0 = 64'hE220A8397B1DCDAF;
  localparam logic [63:0] SEED0_W1 = 64'h6E789E6AA1B965F4;

  localparam int XS_SHL  = 23;
  localparam int XS_SHR  = 18;
  localparam int XS_SHB  = 5;
  localparam int MIX_SH1 = 30;
  localparam int MIX_SH2 = 27;
  localparam int MIX_SH3 = 31;
  localparam int UP_SH   = 32;
  localparam int FRAC_SH = 40;

  localparam int QDEPTH = 2;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    MODE_RESEED = 3'd0,
    MODE_LOAD   = 3'd1,
    MODE_RAW    = 3'd2,
    MODE_UPPER  = 3'd3,
    MODE_FRAC   = 3'd4,
    MODE_RANGE  = 3'd5,
    MODE_FORK   = 3'd6,
    MODE_READ   = 3'd7
  } mode_e;

  // Classified request as queued between front and back.
  typedef struct packed {
    mode_e              mode;
    logic [63:0]        seed_or_low_word;
    logic [63:0]        high_word;
    logic signed [31:0] range_low;
    logic [31:0]        span;
    logic               empty_range;
    logic [31:0]        fork_tag;
  } job_t;

  typedef struct packed {
    logic [63:0]        result_word;
    logic [63:0]        second_word;
    logic signed [31:0] range_result;
  } res_t;
endpackage
`default_nettype wire

// ===== design/xrs_if.sv =====
// Request and result channel interfaces.
`default_nettype none
interface xrs_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [63:0]        seed_or_low_word;
  logic [63:0]        high_word;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  logic [31:0]        fork_tag;
  modport source (output valid, mode, seed_or_low_word, high_word, range_low, range_high,
                  fork_tag, input ready);
  modport sink (input valid, mode, seed_or_low_word, high_word, range_low, range_high,
                fork_tag, output ready);
endinterface

interface xrs_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        result_word;
  logic [63:0]        second_word;
  logic signed [31:0] range_result;
  modport source (output valid, result_word, second_word, range_result, input ready);
  modport sink (input valid, result_word, second_word, range_result, output ready);
endinterface
`default_nettype wire

// ===== design/xrs_front.sv =====
// Request intake: classifies requests and queues them for the back end.
`default_nettype none
module xrs_front import xrs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  xrs_in_if.sink    in_ch,
  output job_t      job,
  output logic      job_vld,
  input  wire logic job_pop
);
  job_t            q_r [QDEPTH];
  logic [QA_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] cnt_r;
  logic            push;
  job_t            cls;

  assign in_ch.ready = (cnt_r != QC_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    cls.mode             = mode_e'(in_ch.mode);
    cls.seed_or_low_word = in_ch.seed_or_low_word;
    cls.high_word        = in_ch.high_word;
    cls.range_low        = in_ch.range_low;
    cls.span             = in_ch.range_high - in_ch.range_low;
    cls.empty_range      = (in_ch.range_high <= in_ch.range_low);
    cls.fork_tag         = in_ch.fork_tag;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (job_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !job_pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && job_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign job     = q_r[rd_ptr_r];
  assign job_vld = (cnt_r != '0);
endmodule
`default_nettype wire

// ===== design/xrs_back.sv =====
// Execution engine: generator state, SplitMix sequencer, shared multiplier, result register.
`default_nettype none
`include "xorshift128plus_random_source_core_assert.svh"
module xrs_back import xrs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire job_t  job,
  input  wire logic  job_vld,
  output logic       job_pop,
  xrs_out_if.source  out_ch
);
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL    = 7'b0000010,
    ST_MIXB   = 7'b0000100,
    ST_MIXC   = 7'b0001000,
    ST_FORKX  = 7'b0010000,
    ST_RANGE1 = 7'b0100000,
    ST_RANGE2 = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {K_GAMMA, K_MIX_A, K_MIX_B} ksel_t;

  state_t      state_r, state_nxt, ret_r, ret_nxt;
  ksel_t       ksel_r, ksel_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [63:0] w0_r, w0_nxt, w1_r, w1_nxt;
  logic [63:0] acc_r, acc_nxt, op_r, op_nxt, prod_r, prod_nxt, draw_r, draw_nxt;
  logic        dcnt_r, dcnt_nxt;
  mode_e       mode_r, mode_nxt;
  logic [31:0] dhi_r, dhi_nxt, span_r, span_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic        out_vld_r, out_vld_nxt;
  res_t        out_res_r, res;
  logic        res_fin;

  logic [63:0] kval, xa, adv_w1, adv_sum, mix_d, acc2, mul_p, r1_fix;
  logic [31:0] mul_a, mul_b, rng_sum;
  logic        can_pop;

  // xorshift128+ step from the current state.
  assign xa      = w0_r ^ (w0_r << XS_SHL);
  assign adv_w1  = xa ^ w1_r ^ (xa >> XS_SHR) ^ (w1_r >> XS_SHB);
  assign adv_sum = adv_w1 + w1_r;

  assign mix_d   = prod_r ^ (prod_r >> MIX_SH3);
  assign r1_fix  = (draw_r == '0 && mix_d == '0) ? GAMMA_K : mix_d;
  assign rng_sum = lo_r + prod_r[63:32];

  always_comb begin
    case (ksel_r)
      K_GAMMA: kval = GAMMA_K;
      K_MIX_A: kval = MIX_A_K;
      K_MIX_B: kval = MIX_B_K;
      default: kval = '0;
    endcase
  end

  // One 32x32 multiplier; a 64x64 low product takes three passes.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_RANGE1) begin
      mul_a = dhi_r;
      mul_b = span_r;
    end else begin
      case (step_r)
        2'd0: begin mul_a = op_r[31:0];  mul_b = kval[31:0];  end
        2'd1: begin mul_a = op_r[63:32]; mul_b = kval[31:0];  end
        2'd2: begin mul_a = op_r[31:0];  mul_b = kval[63:32]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign can_pop = job_vld && (!out_vld_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    ksel_nxt  = ksel_r;
    step_nxt  = step_r;
    w0_nxt    = w0_r;
    w1_nxt    = w1_r;
    acc_nxt   = acc_r;
    op_nxt    = op_r;
    prod_nxt  = prod_r;
    draw_nxt  = draw_r;
    dcnt_nxt  = dcnt_r;
    mode_nxt  = mode_r;
    dhi_nxt   = dhi_r;
    span_nxt  = span_r;
    lo_nxt    = lo_r;
    job_pop   = 1'b0;
    res_fin   = 1'b0;
    res       = '0;
    acc2      = '0;
    case (state_r)
      ST_IDLE: begin
        if (can_pop) begin
          job_pop  = 1'b1;
          mode_nxt = job.mode;
          dcnt_nxt = 1'b0;
          case (job.mode)
            MODE_RESEED: begin
              acc2      = job.seed_or_low_word + GAMMA_K;
              acc_nxt   = acc2;
              op_nxt    = acc2 ^ (acc2 >> MIX_SH1);
              ksel_nxt  = K_MIX_A;
              ret_nxt   = ST_MIXB;
              state_nxt = ST_MUL;
            end
            MODE_LOAD: begin
              w0_nxt  = job.seed_or_low_word;
              w1_nxt  = job.high_word;
              res_fin = 1'b1;
            end
            MODE_RAW, MODE_UPPER, MODE_FRAC: begin
              w0_nxt  = w1_r;
              w1_nxt  = adv_w1;
              res_fin = 1'b1;
              if (job.mode == MODE_RAW) res.result_word = adv_sum;
              else if (job.mode == MODE_UPPER) res.result_word = adv_sum >> UP_SH;
              else res.result_word = adv_sum >> FRAC_SH;
            end
            MODE_RANGE: begin
              if (job.empty_range) begin
                res_fin          = 1'b1;
                res.range_result = job.range_low;
              end else begin
                w0_nxt    = w1_r;
                w1_nxt    = adv_w1;
                dhi_nxt   = adv_sum[63:32];
                span_nxt  = job.span;
                lo_nxt    = job.range_low;
                state_nxt = ST_RANGE1;
              end
            end
            MODE_FORK: begin
              op_nxt    = 64'(job.fork_tag);
              ksel_nxt  = K_GAMMA;
              ret_nxt   = ST_FORKX;
              state_nxt = ST_MUL;
            end
            default: begin
              res_fin         = 1'b1;
              res.result_word = w0_r;
              res.second_word = w1_r;
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_nxt = (step_r == 2'd0) ? mul_p : prod_r + {mul_p[31:0], 32'b0};
        if (step_r == 2'd2) begin
          step_nxt  = 2'd0;
          state_nxt = ret_r;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      ST_FORKX: begin
        acc2      = (prod_r ^ w0_r) + GAMMA_K;
        acc_nxt   = acc2;
        op_nxt    = acc2 ^ (acc2 >> MIX_SH1);
        ksel_nxt  = K_MIX_A;
        ret_nxt   = ST_MIXB;
        state_nxt = ST_MUL;
      end
      ST_MIXB: begin
        op_nxt    = prod_r ^ (prod_r >> MIX_SH2);
        ksel_nxt  = K_MIX_B;
        ret_nxt   = ST_MIXC;
        state_nxt = ST_MUL;
      end
      ST_MIXC: begin
        if (!dcnt_r) begin
          draw_nxt  = mix_d;
          dcnt_nxt  = 1'b1;
          acc2      = ((mode_r == MODE_FORK) ? (acc_r ^ w1_r) : acc_r) + GAMMA_K;
          acc_nxt   = acc2;
          op_nxt    = acc2 ^ (acc2 >> MIX_SH1);
          ksel_nxt  = K_MIX_A;
          ret_nxt   = ST_MIXB;
          state_nxt = ST_MUL;
        end else begin
          res_fin   = 1'b1;
          state_nxt = ST_IDLE;
          if (mode_r == MODE_FORK) begin
            res.result_word = draw_r;
            res.second_word = r1_fix;
          end else begin
            w0_nxt = draw_r;
            w1_nxt = r1_fix;
          end
        end
      end
      ST_RANGE1: begin
        prod_nxt  = mul_p;
        state_nxt = ST_RANGE2;
      end
      ST_RANGE2: begin
        res_fin          = 1'b1;
        res.range_result = rng_sum;
        state_nxt        = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_vld_nxt = res_fin ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ret_r     <= ST_IDLE;
      step_r    <= 2'd0;
      out_vld_r <= 1'b0;
      w0_r      <= SEED0_W0;
      w1_r      <= SEED0_W1;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      step_r    <= step_nxt;
      out_vld_r <= out_vld_nxt;
      w0_r      <= w0_nxt;
      w1_r      <= w1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ksel_r <= ksel_nxt;
    acc_r  <= acc_nxt;
    op_r   <= op_nxt;
    prod_r <= prod_nxt;
    draw_r <= draw_nxt;
    dcnt_r <= dcnt_nxt;
    mode_r <= mode_nxt;
    dhi_r  <= dhi_nxt;
    span_r <= span_nxt;
    lo_r   <= lo_nxt;
    if (res_fin) out_res_r <= res;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_word  = out_res_r.result_word;
  assign out_ch.second_word  = out_res_r.second_word;
  assign out_ch.range_result = out_res_r.range_result;

  `XRS_ASSERT(a_pop_idle, !job_pop || state_r == ST_IDLE, "pop outside idle")
  `XRS_ASSERT(a_fin_room, !res_fin || !out_vld_r || out_ch.ready, "result overwrites pending")
  `XRS_ASSERT(a_step_rng, step_r != 2'd3, "multiplier pass out of range")
  `XRS_ASSERT_NEXT(a_busy_empty, job_pop && state_nxt != ST_IDLE, !out_vld_r, "busy with result held")
endmodule
`default_nettype wire

// ===== design/xorshift128plus_random_source_core.sv =====
// Top level of the xorshift128+ random source with SplitMix64 seeding.
// Load, draws, read and an empty range finish from the engine's idle state; a non-empty
// range passes through ST_RANGE1 and ST_RANGE2, reseed and fork through the multiplier.
// One request in flight in the back end; the shared 32x32 multiplier (three passes per
// 64-bit product) sets the reseed and fork time. A 2-entry queue decouples intake.
// Synchronous active-low reset: state = SplitMix64 outputs for seed zero, queue empty.
`default_nettype none
module xorshift128plus_random_source_core import xrs_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  xrs_in_if.sink    in_ch,
  xrs_out_if.source out_ch
);
  // Classified request from the queue head to the execution engine.
  job_t job;
  logic job_vld;
  logic job_pop;

  // Intake: range compare and span are worked out here, off the engine's path.
  xrs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .job     (job),
    .job_vld (job_vld),
    .job_pop (job_pop)
  );

  // Engine: owns generator state and the result register that holds each transfer.
  xrs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .job     (job),
    .job_vld (job_vld),
    .job_pop (job_pop),
    .out_ch  (out_ch)
  );
endmodule
`default_nettype wire

// ===== test/tb_xorshift128plus_random_source_core.sv =====
// Testbench for the xorshift128+ random source: directed and random requests, scored on the fly.
`timescale 1ns / 1ps
`default_nettype none
module tb_xorshift128plus_random_source_core;
  import xrs_pkg::*;

  typedef struct {
    logic [2:0]         mode;
    logic [63:0]        seed_or_low_word;
    logic [63:0]        high_word;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [31:0]        fork_tag;
  } request_t;

  typedef struct {
    logic [63:0] result_word;
    logic [63:0] second_word;
    logic [31:0] range_result;
  } answer_t;

  logic clk;
  logic rst_n;

  xrs_in_if  in_ch();
  xrs_out_if out_ch();

  xorshift128plus_random_source_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock: 2 ns period.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  logic [63:0] gen_w0;
  logic [63:0] gen_w1;
  int n_errors;
  int n_sent;
  int n_checked;
  int mode_seen[8];
  bit stim_done;

  // SplitMix64 step on an accumulator.
  function automatic logic [63:0] splitmix_next(ref logic [63:0] acc);
    logic [63:0] z;
    acc = acc + GAMMA_K;
    z = acc;
    z = (z ^ (z >> 30)) * MIX_A_K;
    z = (z ^ (z >> 27)) * MIX_B_K;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [63:0] xs_advance();
    logic [63:0] a;
    logic [63:0] b;
    a = gen_w0;
    b = gen_w1;
    gen_w0 = b;
    a = a ^ (a << 23);
    gen_w1 = a ^ b ^ (a >> 18) ^ (b >> 5);
    return gen_w1 + b;
  endfunction

  function automatic void reseed_model(logic [63:0] seed);
    logic [63:0] acc;
    acc = seed;
    gen_w0 = splitmix_next(acc);
    gen_w1 = splitmix_next(acc);
    if (gen_w0 == 64'd0 && gen_w1 == 64'd0) gen_w1 = GAMMA_K;
  endfunction

  // Computes the answer for one accepted request and updates the state copy.
  function automatic answer_t predict_answer(request_t rq);
    answer_t ans;
    logic [63:0] z;
    logic [63:0] m;
    logic [31:0] span;
    ans = '{64'd0, 64'd0, 32'd0};
    case (mode_e'(rq.mode))
      MODE_RESEED: reseed_model(rq.seed_or_low_word);
      MODE_LOAD: begin
        gen_w0 = rq.seed_or_low_word;
        gen_w1 = rq.high_word;
      end
      MODE_RAW:   ans.result_word = xs_advance();
      MODE_UPPER: ans.result_word = xs_advance() >> 32;
      MODE_FRAC:  ans.result_word = xs_advance() >> 40;
      MODE_RANGE: begin
        if (rq.range_high <= rq.range_low) begin
          ans.range_result = rq.range_low;
        end else begin
          span = rq.range_high - rq.range_low;
          m = (xs_advance() >> 32) * {32'd0, span};
          ans.range_result = rq.range_low + m[63:32];
        end
      end
      MODE_FORK: begin
        z = gen_w0 ^ ({32'd0, rq.fork_tag} * GAMMA_K);
        ans.result_word = splitmix_next(z);
        z = z ^ gen_w1;
        ans.second_word = splitmix_next(z);
        if (ans.result_word == 64'd0 && ans.second_word == 64'd0) ans.second_word = GAMMA_K;
      end
      default: begin
        ans.result_word = gen_w0;
        ans.second_word = gen_w1;
      end
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    n_errors++;
    $display("MISMATCH %s at %0t: got %h want %h", what, $realtime, got, want);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic request_t make_req(logic [2:0] md);
    request_t rq;
    rq.mode = md;
    rq.seed_or_low_word = rand64();
    rq.high_word = rand64();
    rq.range_low = $urandom;
    rq.range_high = $urandom;
    rq.fork_tag = $urandom;
    return rq;
  endfunction

  task automatic push_req(request_t rq);
    pending_reqs.push_back(rq);
  endtask

  // Request transfer seen at the last rising edge.
  bit in_taken;
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Driver: presents requests at the falling edge, holds through stalls.
  int  idle_cnt;
  bit  holding;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      idle_cnt <= 0;
      holding <= 1'b0;
    end else if (holding && !in_taken) begin
      // still waiting for the transfer
    end else if (idle_cnt > 0) begin
      in_ch.valid <= 1'b0;
      holding <= 1'b0;
      idle_cnt <= idle_cnt - 1;
    end else if (pending_reqs.size() > 0) begin
      request_t rq;
      rq = pending_reqs.pop_front();
      in_ch.mode <= rq.mode;
      in_ch.seed_or_low_word <= rq.seed_or_low_word;
      in_ch.high_word <= rq.high_word;
      in_ch.range_low <= rq.range_low;
      in_ch.range_high <= rq.range_high;
      in_ch.fork_tag <= rq.fork_tag;
      in_ch.valid <= 1'b1;
      holding <= 1'b1;
      idle_cnt <= gap_len();
    end else begin
      in_ch.valid <= 1'b0;
      holding <= 1'b0;
    end
  end

  // Result-side backpressure.
  int stall_cnt;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_cnt <= 0;
    end else if (stall_cnt > 0) begin
      out_ch.ready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(3) == 0) stall_cnt <= gap_len();
    end
  end

  // Monitor: predicts on request transfers, checks on result transfers.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        request_t rq;
        rq.mode = in_ch.mode;
        rq.seed_or_low_word = in_ch.seed_or_low_word;
        rq.high_word = in_ch.high_word;
        rq.range_low = in_ch.range_low;
        rq.range_high = in_ch.range_high;
        rq.fork_tag = in_ch.fork_tag;
        expected_answers.push_back(predict_answer(rq));
        mode_seen[rq.mode]++;
        n_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        answer_t want;
        if (expected_answers.size() == 0) begin
          n_errors++;
          $display("MISMATCH unexpected result at %0t", $realtime);
        end else begin
          want = expected_answers.pop_front();
          n_checked++;
          if (out_ch.result_word !== want.result_word)
            report_mismatch("result_word", out_ch.result_word, want.result_word);
          if (out_ch.second_word !== want.second_word)
            report_mismatch("second_word", out_ch.second_word, want.second_word);
          if (out_ch.range_result !== want.range_result)
            report_mismatch("range_result", {32'd0, out_ch.range_result},
                            {32'd0, want.range_result});
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    request_t rq;
    int k;
    int r;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_READ;
    in_ch.seed_or_low_word = '0;
    in_ch.high_word = '0;
    in_ch.range_low = '0;
    in_ch.range_high = '0;
    in_ch.fork_tag = '0;
    out_ch.ready = 1'b0;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    stim_done = 0;
    reseed_model(64'd0);
    repeat (4) @(posedge clk);
    #0.5 rst_n = 1'b1;

    // Directed: reset state, every mode, field extremes, empty/full ranges, zero state.
    rq = make_req(MODE_READ);    push_req(rq);
    rq = make_req(MODE_RAW);     push_req(rq);
    rq = make_req(MODE_UPPER);   push_req(rq);
    rq = make_req(MODE_FRAC);    push_req(rq);
    rq = make_req(MODE_RESEED);  rq.seed_or_low_word = '1; push_req(rq);
    rq = make_req(MODE_RESEED);  rq.seed_or_low_word = '0; push_req(rq);
    // seed that lands the first SplitMix accumulator on zero
    rq = make_req(MODE_RESEED);  rq.seed_or_low_word = -GAMMA_K; push_req(rq);
    rq = make_req(MODE_READ);    push_req(rq);
    rq = make_req(MODE_RANGE);   rq.range_low = 32'sh80000000;
    rq.range_high = 32'sh7fffffff; push_req(rq);
    rq = make_req(MODE_RANGE);   rq.range_low = 5; rq.range_high = 5; push_req(rq);
    rq = make_req(MODE_RANGE);   rq.range_low = 32'sh7fffffff;
    rq.range_high = 32'sh80000000; push_req(rq);
    rq = make_req(MODE_RANGE);   rq.range_low = -1; rq.range_high = 0; push_req(rq);
    rq = make_req(MODE_FORK);    rq.fork_tag = '0; push_req(rq);
    rq = make_req(MODE_FORK);    rq.fork_tag = '1; push_req(rq);
    rq = make_req(MODE_LOAD);    rq.seed_or_low_word = '1; rq.high_word = '1; push_req(rq);
    rq = make_req(MODE_RAW);     push_req(rq);
    rq = make_req(MODE_READ);    push_req(rq);
    // all-zero state by load: generator then yields zero
    rq = make_req(MODE_LOAD);    rq.seed_or_low_word = '0; rq.high_word = '0; push_req(rq);
    rq = make_req(MODE_RAW);     push_req(rq);
    rq = make_req(MODE_RANGE);   rq.range_low = -100; rq.range_high = 100; push_req(rq);
    rq = make_req(MODE_FORK);    rq.fork_tag = 0; push_req(rq);
    rq = make_req(MODE_READ);    push_req(rq);

    // Random: draws dominate, reseed/fork/load sprinkled in.
    for (k = 0; k < 1330; k++) begin
      r = $urandom_range(99);
      if (r < 4)       rq = make_req(MODE_RESEED);
      else if (r < 8)  rq = make_req(MODE_LOAD);
      else if (r < 28) rq = make_req(MODE_RAW);
      else if (r < 40) rq = make_req(MODE_UPPER);
      else if (r < 52) rq = make_req(MODE_FRAC);
      else if (r < 80) rq = make_req(MODE_RANGE);
      else if (r < 88) rq = make_req(MODE_FORK);
      else             rq = make_req(MODE_READ);
      if (rq.mode == MODE_RANGE && $urandom_range(1) == 0) begin
        // narrow ranges near a random point
        rq.range_high = rq.range_low + $signed($urandom_range(64)) - 4;
      end
      push_req(rq);
      while (pending_reqs.size() > 8) @(posedge clk);
    end

    while (pending_reqs.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_answers.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d requests, checked %0d results.", n_sent, n_checked);
    $display("Per mode: rs %0d ld %0d raw %0d up %0d fr %0d rng %0d fk %0d rd %0d",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4],
             mode_seen[5], mode_seen[6], mode_seen[7]);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", expected_answers.size());
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
